@@ rtl/gfr_pkg.sv @@
package gfr_pkg;

    localparam int ID_W   = 16;
    localparam int CELL_W = ID_W + 1;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_FIRST = 8'b0000_0100,
        ST_WRD   = 8'b0000_1000,
        ST_WCMP  = 8'b0001_0000,
        ST_HRD   = 8'b0010_0000,
        ST_HCMP  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic take_id;
        logic wide_rd;
        logic wide_chk;
        logic tall_rd;
        logic tall_chk;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last_row;
        logic w_more;
        logic h_more;
        logic id_match;
        logic last_col;
        logic slot_free;
    } sts_t;

endpackage

@@ rtl/gfr_ram.sv @@
module gfr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gfr_ctrl.sv @@
module gfr_ctrl import gfr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  logic kind,
    input  sts_t sts,
    output cmd_t cmd,
    output logic item_stall
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind == KIND_REQUEST)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = ST_FIRST;
                end
                else if (sts.last_row)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FIRST:
            begin
                cmd.take_id = 1'b1;
                state_next  = ST_WRD;
            end
            ST_WRD:
            begin
                cmd.wide_rd = 1'b1;
                state_next  = sts.w_more ? ST_WCMP : ST_HRD;
            end
            ST_WCMP:
            begin
                cmd.wide_chk = 1'b1;
                state_next   = sts.id_match ? ST_WRD : ST_HRD;
            end
            ST_HRD:
            begin
                cmd.tall_rd = 1'b1;
                state_next  = sts.h_more ? ST_HCMP : ST_EMIT;
            end
            ST_HCMP:
            begin
                cmd.tall_chk = 1'b1;
                state_next   = sts.id_match ? ST_HRD : ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output word is free
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/gfr_dp.sv @@
module gfr_dp import gfr_pkg::*; #(
    parameter int U_SIZE = 16,
    parameter int V_SIZE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [3:0]  cell_u,
    input  logic [3:0]  cell_v,
    input  logic [15:0] block_id,
    input  logic        block_opaque,
    input  logic        block_transparent,
    input  logic        block_liquid,
    input  logic [15:0] neighbor_id,
    input  logic        neighbor_opaque,
    input  logic        neighbor_transparent,
    input  logic        rect_stall,
    output logic        rect_valid,
    output logic [3:0]  rect_u,
    output logic [3:0]  rect_v,
    output logic [4:0]  rect_width,
    output logic [4:0]  rect_height,
    output logic [15:0] rect_block,
    output logic        rect_liquid,
    output logic        none_left
);

    localparam int UW    = (U_SIZE > 1) ? $clog2(U_SIZE) : 1;
    localparam int UCW   = $clog2(U_SIZE + 1);
    localparam int VW    = (V_SIZE > 1) ? $clog2(V_SIZE) : 1;
    localparam int VCW   = $clog2(V_SIZE + 1);
    localparam int CELLS = U_SIZE * V_SIZE;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    function automatic logic face_shows(
        input logic [ID_W-1:0] id,
        input logic            opq,
        input logic            trn,
        input logic [ID_W-1:0] nid,
        input logic            nopq,
        input logic            ntrn
    );
        logic res;
        begin
            if (id == '0)
                res = 1'b0;
            else if (!opq && !trn)
                res = 1'b0;
            else if (nid == id)
                res = 1'b0;
            else if (nid == '0)
                res = 1'b1;
            else if (nopq)
                res = 1'b0;
            else if (trn && ntrn)
                res = 1'b0;
            else
                res = 1'b1;
            face_shows = res;
        end
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r, input logic [UW-1:0] c);
        cell_addr = AW'(int'(r) * U_SIZE + int'(c));
    endfunction

    // one flag per cell: set while the cell holds a visible (nonzero) id
    logic [V_SIZE-1:0][U_SIZE-1:0] nz_reg, nz_next;
    logic [UW-1:0]   cu_reg, cu_next;
    logic [VCW-1:0]  cv_reg, cv_next;
    logic [UW-1:0]   u_reg, u_next;
    logic [VW-1:0]   v_reg, v_next;
    logic [UCW-1:0]  w_reg, w_next;
    logic [VCW-1:0]  h_reg, h_next;
    logic [UCW-1:0]  c_reg, c_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            liq_reg, liq_next;
    logic            none_reg, none_next;
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      out_u_reg, out_u_next;
    logic [3:0]      out_v_reg, out_v_next;
    logic [4:0]      out_w_reg, out_w_next;
    logic [4:0]      out_h_reg, out_h_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic            out_liq_reg, out_liq_next;
    logic            out_none_reg, out_none_next;

    logic              in_range;
    logic              shows;
    logic [UW-1:0]     lu;
    logic [VW-1:0]     lv;
    logic              row_ok;
    logic [U_SIZE-1:0] scan_row;
    logic              hit;
    logic [UW-1:0]     hit_u;
    logic [UCW-1:0]    pw;
    logic [VCW-1:0]    th;
    logic [UCW-1:0]    tc_wide;
    logic [UW-1:0]     tc;
    logic              id_match;
    logic              last_col;
    logic              slot_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign in_range = (int'(cell_u) < U_SIZE) && (int'(cell_v) < V_SIZE);
    assign shows    = face_shows(block_id, block_opaque, block_transparent,
                                 neighbor_id, neighbor_opaque, neighbor_transparent);
    assign lu       = UW'(cell_u);
    assign lv       = VW'(cell_v);

    // row scan from the cursor, lowest set flag wins
    assign row_ok = (cv_reg < VCW'(V_SIZE));

    always_comb
    begin
        scan_row = '0;
        hit_u    = '0;
        for (int i = 0; i < U_SIZE; i++)
        begin
            scan_row[i] = row_ok && nz_reg[cv_reg[VW-1:0]][i] && (i >= int'(cu_reg));
        end
        for (int i = U_SIZE - 1; i >= 0; i--)
        begin
            if (scan_row[i])
            begin
                hit_u = UW'(i);
            end
        end
    end

    assign hit      = |scan_row;
    assign pw       = UCW'(u_reg) + w_reg;
    assign th       = VCW'(v_reg) + h_reg;
    assign tc_wide  = UCW'(u_reg) + c_reg;
    assign tc       = tc_wide[UW-1:0];
    assign id_match = (ram_rdata[ID_W-1:0] == id_reg);
    assign last_col = ((c_reg + UCW'(1)) == w_reg);
    assign slot_free = !out_valid_reg || !rect_stall;

    always_comb
    begin
        sts           = '0;
        sts.hit       = hit;
        sts.last_row  = (cv_reg >= VCW'(V_SIZE - 1));
        sts.w_more    = (pw < UCW'(U_SIZE)) ? nz_reg[v_reg][pw[UW-1:0]] : 1'b0;
        sts.h_more    = (th < VCW'(V_SIZE)) ? nz_reg[th[VW-1:0]][tc] : 1'b0;
        sts.id_match  = id_match;
        sts.last_col  = last_col;
        sts.slot_free = slot_free;
    end

    // mask store port
    assign ram_we    = cmd.load && in_range && shows;
    assign ram_waddr = cell_addr(lv, lu);
    assign ram_wdata = {block_liquid, block_id};

    always_comb
    begin
        if (cmd.scan)
            ram_raddr = cell_addr(cv_reg[VW-1:0], hit_u);
        else if (cmd.wide_rd)
            ram_raddr = cell_addr(v_reg, pw[UW-1:0]);
        else if (cmd.tall_rd)
            ram_raddr = cell_addr(th[VW-1:0], tc);
        else
            ram_raddr = '0;
    end

    gfr_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_mask (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        nz_next        = nz_reg;
        cu_next        = cu_reg;
        cv_next        = cv_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        c_next         = c_reg;
        id_next        = id_reg;
        liq_next       = liq_reg;
        none_next      = none_reg;
        out_valid_next = out_valid_reg;
        out_u_next     = out_u_reg;
        out_v_next     = out_v_reg;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        out_id_next    = out_id_reg;
        out_liq_next   = out_liq_reg;
        out_none_next  = out_none_reg;

        if (cmd.load && in_range)
        begin
            nz_next[lv][lu] = shows;
        end

        if (cmd.scan)
        begin
            if (hit)
            begin
                u_next    = hit_u;
                v_next    = cv_reg[VW-1:0];
                w_next    = UCW'(1);
                none_next = 1'b0;
            end
            else if (sts.last_row)
            begin
                none_next = 1'b1;
            end
            else
            begin
                cu_next = '0;
                cv_next = cv_reg + VCW'(1);
            end
        end

        if (cmd.take_id)
        begin
            id_next  = ram_rdata[ID_W-1:0];
            liq_next = ram_rdata[ID_W];
            h_next   = VCW'(1);
            c_next   = '0;
        end

        if (cmd.wide_chk && id_match)
        begin
            w_next = w_reg + UCW'(1);
        end

        if (cmd.tall_chk && id_match)
        begin
            if (last_col)
            begin
                h_next = h_reg + VCW'(1);
                c_next = '0;
            end
            else
            begin
                c_next = c_reg + UCW'(1);
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_none_next  = none_reg;
            if (none_reg)
            begin
                cu_next      = '0;
                cv_next      = '0;
                out_u_next   = '0;
                out_v_next   = '0;
                out_w_next   = '0;
                out_h_next   = '0;
                out_id_next  = '0;
                out_liq_next = 1'b0;
            end
            else
            begin
                out_u_next   = 4'(u_reg);
                out_v_next   = 4'(v_reg);
                out_w_next   = 5'(w_reg);
                out_h_next   = 5'(h_reg);
                out_id_next  = id_reg;
                out_liq_next = liq_reg;
                // drop the covered cells
                for (int r = 0; r < V_SIZE; r++)
                begin
                    for (int c = 0; c < U_SIZE; c++)
                    begin
                        if ((VCW'(r) >= VCW'(v_reg)) && (VCW'(r) < th) &&
                            (UCW'(c) >= UCW'(u_reg)) && (UCW'(c) < pw))
                        begin
                            nz_next[r][c] = 1'b0;
                        end
                    end
                end
                if (pw == UCW'(U_SIZE))
                begin
                    cu_next = '0;
                    cv_next = VCW'(v_reg) + VCW'(1);
                end
                else
                begin
                    cu_next = pw[UW-1:0];
                    cv_next = VCW'(v_reg);
                end
            end
        end
        else if (!rect_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg        <= '0;
            cu_reg        <= '0;
            cv_reg        <= '0;
            none_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nz_reg        <= nz_next;
            cu_reg        <= cu_next;
            cv_reg        <= cv_next;
            none_reg      <= none_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        c_reg        <= c_next;
        id_reg       <= id_next;
        liq_reg      <= liq_next;
        out_u_reg    <= out_u_next;
        out_v_reg    <= out_v_next;
        out_w_reg    <= out_w_next;
        out_h_reg    <= out_h_next;
        out_id_reg   <= out_id_next;
        out_liq_reg  <= out_liq_next;
        out_none_reg <= out_none_next;
    end

    assign rect_valid  = out_valid_reg;
    assign rect_u      = out_u_reg;
    assign rect_v      = out_v_reg;
    assign rect_width  = out_w_reg;
    assign rect_height = out_h_reg;
    assign rect_block  = out_id_reg;
    assign rect_liquid = out_liq_reg;
    assign none_left   = out_none_reg;

endmodule

@@ rtl/greedy_face_rectangle_merger_top.sv @@
// Greedy face merger for one U_SIZE x V_SIZE slice. A load word (kind 0) decides face
// visibility and writes the cell into the mask. A request word (kind 1) returns one
// rectangle, or none_left once the slice is drained. The scan visits rows from the
// cursor; the merge then probes cells while widening along u and growing along v, and
// each of those two loops ends at the slice edge, on an empty cell or on an id mismatch.
// A stalled output word holds the next result back for as long as it waits.
// Probes go through the single read port of the mask RAM, whose read data is
// registered; per-cell presence flags are kept in flip-flops, so reset clears the
// slice at once and no clearing pass is needed. Input is stalled while a request is
// in work; a finished result sits in an output register until taken.
module greedy_face_rectangle_merger_top import gfr_pkg::*; #(
    parameter int U_SIZE = 16,
    parameter int V_SIZE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [3:0]  cell_u,
    input  logic [3:0]  cell_v,
    input  logic [15:0] block_id,
    input  logic        block_opaque,
    input  logic        block_transparent,
    input  logic        block_liquid,
    input  logic [15:0] neighbor_id,
    input  logic        neighbor_opaque,
    input  logic        neighbor_transparent,
    output logic        rect_valid,
    input  logic        rect_stall,
    output logic [3:0]  rect_u,
    output logic [3:0]  rect_v,
    output logic [4:0]  rect_width,
    output logic [4:0]  rect_height,
    output logic [15:0] rect_block,
    output logic        rect_liquid,
    output logic        none_left
);

    cmd_t cmd;
    sts_t sts;

    gfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (kind),
        .sts        (sts),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    gfr_dp #(
        .U_SIZE (U_SIZE),
        .V_SIZE (V_SIZE)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .cell_u               (cell_u),
        .cell_v               (cell_v),
        .block_id             (block_id),
        .block_opaque         (block_opaque),
        .block_transparent    (block_transparent),
        .block_liquid         (block_liquid),
        .neighbor_id          (neighbor_id),
        .neighbor_opaque      (neighbor_opaque),
        .neighbor_transparent (neighbor_transparent),
        .rect_stall           (rect_stall),
        .rect_valid           (rect_valid),
        .rect_u               (rect_u),
        .rect_v               (rect_v),
        .rect_width           (rect_width),
        .rect_height          (rect_height),
        .rect_block           (rect_block),
        .rect_liquid          (rect_liquid),
        .none_left            (none_left)
    );

    // a real rectangle always carries a visible id
    a_rect_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rect_valid && !none_left) |-> (rect_block != '0))
        else $error("rectangle with zero block id");

    a_none_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rect_valid && none_left) |->
        (rect_block == '0 && rect_width == '0 && rect_height == '0 && !rect_liquid))
        else $error("none_left word with nonzero fields");

    // a new word only follows a busy request
    a_word_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rect_valid) |-> $past(item_stall))
        else $error("result word without a request in work");

endmodule

@@ verif/greedy_face_rectangle_merger_top_test.sv @@
`timescale 1ns / 100ps

module greedy_face_rectangle_merger_top_test;
    import gfr_pkg::*;

    localparam int U_SIZE = 16;
    localparam int V_SIZE = 16;
    localparam int CELLS = U_SIZE * V_SIZE;
    localparam int ITEM_GOAL = 950;

    typedef struct packed {
        logic        pause;
        logic        kind;
        logic [3:0]  u;
        logic [3:0]  v;
        logic [15:0] id;
        logic        opq;
        logic        trn;
        logic        liq;
        logic [15:0] nid;
        logic        nopq;
        logic        ntrn;
    } face_word_t;

    typedef struct packed {
        logic [3:0]  u;
        logic [3:0]  v;
        logic [4:0]  w;
        logic [4:0]  h;
        logic [15:0] blk;
        logic        liq;
        logic        none;
    } rect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        kind = KIND_LOAD;
    logic [3:0]  cell_u = '0;
    logic [3:0]  cell_v = '0;
    logic [15:0] block_id = '0;
    logic        block_opaque = 1'b0;
    logic        block_transparent = 1'b0;
    logic        block_liquid = 1'b0;
    logic [15:0] neighbor_id = '0;
    logic        neighbor_opaque = 1'b0;
    logic        neighbor_transparent = 1'b0;
    logic        rect_valid;
    logic        rect_stall = 1'b0;
    logic [3:0]  rect_u;
    logic [3:0]  rect_v;
    logic [4:0]  rect_width;
    logic [4:0]  rect_height;
    logic [15:0] rect_block;
    logic        rect_liquid;
    logic        none_left;

    greedy_face_rectangle_merger_top #(
        .U_SIZE(U_SIZE),
        .V_SIZE(V_SIZE)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_stall           (item_stall),
        .kind                 (kind),
        .cell_u               (cell_u),
        .cell_v               (cell_v),
        .block_id             (block_id),
        .block_opaque         (block_opaque),
        .block_transparent    (block_transparent),
        .block_liquid         (block_liquid),
        .neighbor_id          (neighbor_id),
        .neighbor_opaque      (neighbor_opaque),
        .neighbor_transparent (neighbor_transparent),
        .rect_valid           (rect_valid),
        .rect_stall           (rect_stall),
        .rect_u               (rect_u),
        .rect_v               (rect_v),
        .rect_width           (rect_width),
        .rect_height          (rect_height),
        .rect_block           (rect_block),
        .rect_liquid          (rect_liquid),
        .none_left            (none_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the face mask
    logic [15:0] mask_id [CELLS] = '{default: '0};
    logic        mask_liq [CELLS] = '{default: 1'b0};
    int          scan_pos = 0;
    rect_t       rects_due[$];
    face_word_t  pending[$];
    face_word_t  cur;
    bit          draining;
    int          errors = 0;
    int          cyc = 0;
    bit          calm;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // one window in four with no idling on either side
    assign calm = ((cyc / 2000) % 4) == 1;

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 32);
    endfunction

    function automatic bit face_shown(face_word_t wd);
        if (wd.id == 16'd0) return 1'b0;
        if (!wd.opq && !wd.trn) return 1'b0;
        if (wd.nid == wd.id) return 1'b0;
        if (wd.nid == 16'd0) return 1'b1;
        if (wd.nopq) return 1'b0;
        if (wd.trn && wd.ntrn) return 1'b0;
        return 1'b1;
    endfunction

    task automatic merge_step(face_word_t wd);
        int pos;
        int idx;
        int u;
        int v;
        int w;
        int h;
        int base;
        int c;
        int r;
        bit grow;
        logic [15:0] id;
        rect_t rc;
        if (wd.kind == KIND_LOAD)
        begin
            if (wd.u >= U_SIZE || wd.v >= V_SIZE) return;
            idx = wd.u + wd.v * U_SIZE;
            if (face_shown(wd))
            begin
                mask_id[idx] = wd.id;
                mask_liq[idx] = wd.liq;
            end
            else
            begin
                mask_id[idx] = '0;
                mask_liq[idx] = 1'b0;
            end
            return;
        end
        pos = scan_pos;
        while (pos < CELLS && mask_id[pos] == 16'd0) pos++;
        rc = '0;
        if (pos >= CELLS)
        begin
            scan_pos = 0;
            rc.none = 1'b1;
            rects_due = {rects_due, rc};
            return;
        end
        u = pos % U_SIZE;
        v = pos / U_SIZE;
        id = mask_id[pos];
        w = 1;
        while (u + w < U_SIZE && mask_id[pos + w] == id) w++;
        h = 1;
        grow = 1'b1;
        while (grow && v + h < V_SIZE)
        begin
            base = (v + h) * U_SIZE + u;
            for (c = 0; c < w && grow; c++)
                if (mask_id[base + c] != id) grow = 1'b0;
            if (grow) h++;
        end
        rc.u = u[3:0];
        rc.v = v[3:0];
        rc.w = w[4:0];
        rc.h = h[4:0];
        rc.blk = id;
        rc.liq = mask_liq[pos];
        rects_due = {rects_due, rc};
        for (r = 0; r < h; r++)
        begin
            base = (v + r) * U_SIZE + u;
            for (c = 0; c < w; c++)
            begin
                mask_id[base + c] = '0;
                mask_liq[base + c] = 1'b0;
            end
        end
        scan_pos = pos + w;
    endtask

    // word driver
    always @(posedge clk or negedge rst_n)
    begin
        bit send;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            draining = 1'b0;
        end
        else
        begin
            send = item_valid;
            if (item_valid && !item_stall)
            begin
                merge_step(cur);
                send = 1'b0;
            end
            if (!send)
            begin
                if (draining && rects_due.size() == 0) draining = 1'b0;
                if (!draining && pending.size() > 0 && pending[0].pause)
                begin
                    void'(pending.pop_front());
                    draining = 1'b1;
                end
                if (!draining && pending.size() > 0 && !take_break())
                begin
                    cur = pending.pop_front();
                    send = 1'b1;
                    kind <= cur.kind;
                    cell_u <= cur.u;
                    cell_v <= cur.v;
                    block_id <= cur.id;
                    block_opaque <= cur.opq;
                    block_transparent <= cur.trn;
                    block_liquid <= cur.liq;
                    neighbor_id <= cur.nid;
                    neighbor_opaque <= cur.nopq;
                    neighbor_transparent <= cur.ntrn;
                end
            end
            item_valid <= send;
        end
    end

    // rectangle monitor
    always @(posedge clk or negedge rst_n)
    begin
        rect_t exp_rc;
        if (!rst_n)
        begin
            rect_stall <= 1'b0;
        end
        else
        begin
            if (rect_valid && !rect_stall)
            begin
                if (rects_due.size() == 0)
                begin
                    $error("rectangle word with nothing expected: u=%0d v=%0d block=%0h",
                           rect_u, rect_v, rect_block);
                    errors++;
                end
                else
                begin
                    exp_rc = rects_due.pop_front();
                    if (rect_u !== exp_rc.u)
                    begin
                        $error("rect_u: expected %0d, got %0d", exp_rc.u, rect_u);
                        errors++;
                    end
                    if (rect_v !== exp_rc.v)
                    begin
                        $error("rect_v: expected %0d, got %0d", exp_rc.v, rect_v);
                        errors++;
                    end
                    if (rect_width !== exp_rc.w)
                    begin
                        $error("rect_width: expected %0d, got %0d", exp_rc.w, rect_width);
                        errors++;
                    end
                    if (rect_height !== exp_rc.h)
                    begin
                        $error("rect_height: expected %0d, got %0d", exp_rc.h, rect_height);
                        errors++;
                    end
                    if (rect_block !== exp_rc.blk)
                    begin
                        $error("rect_block: expected %0h, got %0h", exp_rc.blk, rect_block);
                        errors++;
                    end
                    if (rect_liquid !== exp_rc.liq)
                    begin
                        $error("rect_liquid: expected %0d, got %0d", exp_rc.liq, rect_liquid);
                        errors++;
                    end
                    if (none_left !== exp_rc.none)
                    begin
                        $error("none_left: expected %0d, got %0d", exp_rc.none, none_left);
                        errors++;
                    end
                end
            end
            rect_stall <= take_break();
        end
    end

    int words_queued;

    function automatic face_word_t rand_word();
        face_word_t wd;
        wd.pause = 1'b0;
        wd.kind = 1'($urandom_range(1));
        wd.u = 4'($urandom);
        wd.v = 4'($urandom);
        wd.id = 16'($urandom);
        wd.opq = 1'($urandom_range(1));
        wd.trn = 1'($urandom_range(1));
        wd.liq = 1'($urandom_range(1));
        wd.nid = 16'($urandom);
        wd.nopq = 1'($urandom_range(1));
        wd.ntrn = 1'($urandom_range(1));
        return wd;
    endfunction

    task automatic queue_word(face_word_t wd);
        pending = {pending, wd};
        if (!wd.pause) words_queued++;
    endtask

    task automatic queue_pause();
        face_word_t wd;
        wd = '0;
        wd.pause = 1'b1;
        queue_word(wd);
    endtask

    task automatic queue_request();
        face_word_t wd;
        wd = rand_word();
        wd.kind = KIND_REQUEST;
        queue_word(wd);
    endtask

    // own flags are {opaque, transparent, liquid}, neighbor flags {opaque, transparent}
    task automatic queue_load(int u, int v, logic [15:0] id, logic [2:0] own,
                              logic [15:0] nid, logic [1:0] nb);
        face_word_t wd;
        wd.pause = 1'b0;
        wd.kind = KIND_LOAD;
        wd.u = 4'(u);
        wd.v = 4'(v);
        wd.id = id;
        {wd.opq, wd.trn, wd.liq} = own;
        wd.nid = nid;
        {wd.nopq, wd.ntrn} = nb;
        queue_word(wd);
    endtask

    // load that mostly ends up visible, with some flag noise
    task automatic queue_face(int u, int v, logic [15:0] id);
        face_word_t wd;
        wd = rand_word();
        wd.kind = KIND_LOAD;
        wd.u = 4'(u);
        wd.v = 4'(v);
        wd.id = id;
        if ($urandom_range(5) != 0)
        begin
            if (!wd.opq) wd.trn = 1'b1;
            if ($urandom_range(1))
            begin
                wd.nid = '0;
            end
            else
            begin
                if (wd.nid == id) wd.nid = ~id;
                wd.nopq = 1'b0;
                if (wd.trn) wd.ntrn = 1'b0;
            end
        end
        queue_word(wd);
    endtask

    initial
    begin
        int n_rects;
        int u0;
        int v0;
        int w;
        int h;
        int i;
        int j;
        int k;
        bit sheet_done;
        logic [15:0] pal [2];
        logic [15:0] rid;
        face_word_t wd;

        words_queued = 0;
        sheet_done = 1'b0;

        // empty slice
        queue_request();
        // visibility rule: row 0 takes one branch per cell, and cell (15,15) a hidden case
        queue_load(0, 0, 16'h0000, 3'b100, 16'h0000, 2'b00);
        queue_load(1, 0, 16'h0005, 3'b001, 16'h0000, 2'b00);
        queue_load(2, 0, 16'h0007, 3'b100, 16'h0007, 2'b00);
        queue_load(3, 0, 16'h0009, 3'b100, 16'h0000, 2'b10);
        queue_load(4, 0, 16'h0009, 3'b010, 16'h0003, 2'b10);
        queue_load(5, 0, 16'h0009, 3'b010, 16'h0003, 2'b01);
        queue_load(6, 0, 16'h0009, 3'b011, 16'h0003, 2'b00);
        queue_load(7, 0, 16'h0009, 3'b100, 16'h0003, 2'b01);
        queue_load(15, 15, 16'hFFFF, 3'b111, 16'hFFFE, 2'b01);
        // isolated cell, then a pair merged on id with mixed liquid flags
        queue_request();
        queue_request();
        // load behind the cursor is found only after the rewind
        queue_load(0, 0, 16'h1234, 3'b100, 16'h0000, 2'b00);
        queue_request();
        queue_request();
        queue_request();
        queue_request();
        // rewrite of one cell
        queue_load(2, 2, 16'h0003, 3'b100, 16'h0000, 2'b00);
        queue_load(2, 2, 16'h0004, 3'b101, 16'h0000, 2'b00);
        queue_load(3, 2, 16'h0004, 3'b100, 16'hFFFF, 2'b11);
        queue_request();
        queue_request();
        queue_pause();

        while (words_queued < ITEM_GOAL)
        begin
            k = $urandom_range(99);
            if (!sheet_done && words_queued > 300)
            begin
                // whole slice of one id, then two requests to merge it
                sheet_done = 1'b1;
                rid = 16'($urandom_range(1, 65535));
                for (j = 0; j < V_SIZE; j++)
                    for (i = 0; i < U_SIZE; i++)
                        queue_load(i, j, rid, {1'b1, 1'b0, $urandom_range(1) == 1},
                                   16'h0000, 2'b00);
                queue_request();
                queue_request();
            end
            else if (k < 80)
            begin
                pal[0] = ($urandom_range(7) == 0) ? 16'hFFFF :
                         16'($urandom_range(1, 65535));
                pal[1] = $urandom_range(1) ? pal[0] : 16'($urandom_range(1, 65535));
                n_rects = $urandom_range(1, 4);
                for (k = 0; k < n_rects; k++)
                begin
                    u0 = $urandom_range(U_SIZE - 1);
                    v0 = $urandom_range(V_SIZE - 1);
                    w = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                    h = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                    if (u0 + w > U_SIZE) w = U_SIZE - u0;
                    if (v0 + h > V_SIZE) h = V_SIZE - v0;
                    if (w * h > 24) h = (24 / w > 0) ? 24 / w : 1;
                    rid = pal[$urandom_range(1)];
                    for (j = 0; j < h; j++)
                        for (i = 0; i < w; i++)
                            queue_face(u0 + i, v0 + j, rid);
                end
                for (k = 0; k < n_rects * 2 + 2; k++)
                begin
                    if ($urandom_range(7) == 0)
                        queue_face($urandom_range(U_SIZE - 1), $urandom_range(V_SIZE - 1),
                                   pal[0]);
                    queue_request();
                end
                if ($urandom_range(3) == 0) queue_pause();
            end
            else
            begin
                // raw noise words
                for (k = $urandom_range(1, 6); k > 0; k--)
                begin
                    wd = rand_word();
                    queue_word(wd);
                end
            end
        end
        // drain what is left so the slice ends clear
        for (k = 0; k < 8; k++) queue_request();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || item_valid || draining || rects_due.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gfr_pkg.sv
rtl/gfr_ram.sv
rtl/gfr_ctrl.sv
rtl/gfr_dp.sv
rtl/greedy_face_rectangle_merger_top.sv
verif/greedy_face_rectangle_merger_top_test.sv
